[sv/delp_pkg.sv]
package delp_pkg;

  // Default sizes of the debounce counter and the internal time base
  localparam int DEF_COUNT_BITS = 16;
  localparam int DEF_TIME_BITS  = 32;

  // Fixed field and register widths
  localparam int MS_W      = 32;
  localparam int LIMIT_W   = 16;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 4;

  // Register reset values
  localparam logic [LIMIT_W-1:0] RST_DEBOUNCE_LIMIT = LIMIT_W'(8);
  localparam logic               RST_ACTIVE_LEVEL   = 1'b1;
  localparam logic [MS_W-1:0]    RST_HIGH_LONG_MS   = '0;
  localparam logic [MS_W-1:0]    RST_LOW_LONG_MS    = '0;

  // Register word indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_DEBOUNCE_LIMIT = 2'd0,
    REG_ACTIVE_LEVEL   = 2'd1,
    REG_HIGH_LONG_MS   = 2'd2,
    REG_LOW_LONG_MS    = 2'd3
  } reg_idx_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [LIMIT_W-1:0] debounce_limit;
    logic               active_level;
    logic [MS_W-1:0]    high_long_limit_ms;
    logic [MS_W-1:0]    low_long_limit_ms;
  } cfg_t;

  // One sample tick
  typedef struct packed {
    logic            pin_level;
    logic [MS_W-1:0] now_ms;
    logic            ignore_next_rise;
    logic            ignore_next_fall;
    logic            clear_events;
    logic            check_long;
  } item_t;

  // One result beat
  typedef struct packed {
    logic            debounced_level;
    logic            rise_pending;
    logic            fall_pending;
    logic            edge_pending;
    logic [MS_W-1:0] high_time_ms;
    logic [MS_W-1:0] low_time_ms;
    logic            high_long;
    logic            low_long;
  } res_t;

  // Single-bit state of the debouncer
  typedef struct packed {
    logic stable_level;
    logic rise_flag;
    logic fall_flag;
    logic any_flag;
    logic skip_rise;
    logic skip_fall;
    logic rise_valid;
    logic fall_valid;
  } flags_t;

endpackage

[sv/debounce_edge_long_press_core.sv]
// Counter debouncer with edge flags and long-press detection.
// An accepted input beat is held in the input register; its result then sits in the result register on out_valid.
// Throughput: one beat per cycle; input register and result register are both
// held only while out_ready is low, and one pass of the step logic updates all state.
// Reset (rst_n low, synchronous): state, stamps and flags cleared, registers to defaults.
module debounce_edge_long_press_core #(
  parameter int COUNT_BITS = delp_pkg::DEF_COUNT_BITS,
  parameter int TIME_BITS  = delp_pkg::DEF_TIME_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [delp_pkg::APB_AW-1:0] paddr,
  input  logic [delp_pkg::APB_DW-1:0] pwdata,
  output logic [delp_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_pin_level,
  input  logic [delp_pkg::MS_W-1:0]   in_now_ms,
  input  logic                        in_ignore_next_rise,
  input  logic                        in_ignore_next_fall,
  input  logic                        in_clear_events,
  input  logic                        in_check_long,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_debounced_level,
  output logic                        out_rise_pending,
  output logic                        out_fall_pending,
  output logic                        out_edge_pending,
  output logic [delp_pkg::MS_W-1:0]   out_high_time_ms,
  output logic [delp_pkg::MS_W-1:0]   out_low_time_ms,
  output logic                        out_high_long,
  output logic                        out_low_long
);
  import delp_pkg::*;

  cfg_t                  cfg_r;
  reg_idx_t              reg_idx;
  logic                  cfg_wr;

  item_t                 item_r;
  logic                  item_vld_r;
  res_t                  res_r;
  logic                  res_vld_r;
  logic                  advance;

  flags_t                flags_r;
  flags_t                flags_nxt;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;
  logic [TIME_BITS-1:0]  rise_stamp_r;
  logic [TIME_BITS-1:0]  rise_stamp_nxt;
  logic [TIME_BITS-1:0]  fall_stamp_r;
  logic [TIME_BITS-1:0]  fall_stamp_nxt;
  res_t                  res_nxt;

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_limit     <= RST_DEBOUNCE_LIMIT;
      cfg_r.active_level       <= RST_ACTIVE_LEVEL;
      cfg_r.high_long_limit_ms <= RST_HIGH_LONG_MS;
      cfg_r.low_long_limit_ms  <= RST_LOW_LONG_MS;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEBOUNCE_LIMIT: cfg_r.debounce_limit     <= pwdata[LIMIT_W-1:0];
        REG_ACTIVE_LEVEL:   cfg_r.active_level       <= pwdata[0];
        REG_HIGH_LONG_MS:   cfg_r.high_long_limit_ms <= pwdata[MS_W-1:0];
        REG_LOW_LONG_MS:    cfg_r.low_long_limit_ms  <= pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE_LIMIT: prdata = APB_DW'(cfg_r.debounce_limit);
      REG_ACTIVE_LEVEL:   prdata = APB_DW'(cfg_r.active_level);
      REG_HIGH_LONG_MS:   prdata = APB_DW'(cfg_r.high_long_limit_ms);
      REG_LOW_LONG_MS:    prdata = APB_DW'(cfg_r.low_long_limit_ms);
      default:            prdata = '0;
    endcase
  end

  // Move the held beat into the result register when that register frees up
  assign advance  = item_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.pin_level        <= in_pin_level;
      item_r.now_ms           <= in_now_ms;
      item_r.ignore_next_rise <= in_ignore_next_rise;
      item_r.ignore_next_fall <= in_ignore_next_fall;
      item_r.clear_events     <= in_clear_events;
      item_r.check_long       <= in_check_long;
    end
  end

  delp_step #(
    .COUNT_BITS (COUNT_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_step (
    .cfg            (cfg_r),
    .item           (item_r),
    .flags          (flags_r),
    .count          (count_r),
    .rise_stamp     (rise_stamp_r),
    .fall_stamp     (fall_stamp_r),
    .flags_nxt      (flags_nxt),
    .count_nxt      (count_nxt),
    .rise_stamp_nxt (rise_stamp_nxt),
    .fall_stamp_nxt (fall_stamp_nxt),
    .res            (res_nxt)
  );

  // Commit debouncer state as the beat advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r      <= '0;
      count_r      <= '0;
      rise_stamp_r <= '0;
      fall_stamp_r <= '0;
    end else if (advance) begin
      flags_r      <= flags_nxt;
      count_r      <= count_nxt;
      rise_stamp_r <= rise_stamp_nxt;
      fall_stamp_r <= fall_stamp_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= 1'b1;
    end else if (out_ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = res_vld_r;
  assign out_debounced_level = res_r.debounced_level;
  assign out_rise_pending    = res_r.rise_pending;
  assign out_fall_pending    = res_r.fall_pending;
  assign out_edge_pending    = res_r.edge_pending;
  assign out_high_time_ms    = res_r.high_time_ms;
  assign out_low_time_ms     = res_r.low_time_ms;
  assign out_high_long       = res_r.high_long;
  assign out_low_long        = res_r.low_long;

endmodule

[sv/delp_step.sv]
module delp_step #(
  parameter int COUNT_BITS = delp_pkg::DEF_COUNT_BITS,
  parameter int TIME_BITS  = delp_pkg::DEF_TIME_BITS
) (
  input  delp_pkg::cfg_t          cfg,
  input  delp_pkg::item_t         item,
  input  delp_pkg::flags_t        flags,
  input  logic [COUNT_BITS-1:0]   count,
  input  logic [TIME_BITS-1:0]    rise_stamp,
  input  logic [TIME_BITS-1:0]    fall_stamp,
  output delp_pkg::flags_t        flags_nxt,
  output logic [COUNT_BITS-1:0]   count_nxt,
  output logic [TIME_BITS-1:0]    rise_stamp_nxt,
  output logic [TIME_BITS-1:0]    fall_stamp_nxt,
  output delp_pkg::res_t          res
);
  import delp_pkg::*;

  localparam int CMP_W  = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam int LONG_W = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [CMP_W-1:0]      limit_x;
  logic [CMP_W-1:0]      cnt_x;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [TIME_BITS-1:0]  now_t;
  logic [TIME_BITS-1:0]  rise_st;
  logic [TIME_BITS-1:0]  fall_st;
  logic [TIME_BITS-1:0]  el_hi;
  logic [TIME_BITS-1:0]  el_lo;
  logic                  pin_act;
  logic                  rise_ev;
  logic                  fall_ev;
  logic                  hl;
  logic                  ll;
  flags_t                f;

  always_comb begin
    // Latch ignore requests before the edge test
    f           = flags;
    f.skip_rise = flags.skip_rise | item.ignore_next_rise;
    f.skip_fall = flags.skip_fall | item.ignore_next_fall;

    // Saturating up/down counter
    limit_x = CMP_W'(cfg.debounce_limit);
    cnt_x   = CMP_W'(count);
    pin_act = (item.pin_level == cfg.active_level);
    cnt_new = count;
    if (pin_act) begin
      if ((cnt_x < limit_x) && (count != COUNT_MAX)) begin
        cnt_new = count + COUNT_BITS'(1);
      end
    end else if (count != '0) begin
      cnt_new = count - COUNT_BITS'(1);
    end

    // Edge detect against the level held before this tick
    now_t   = TIME_BITS'(item.now_ms);
    rise_ev = !flags.stable_level && (CMP_W'(cnt_new) >= limit_x);
    fall_ev = flags.stable_level && (cnt_new == '0);
    rise_st = rise_stamp;
    fall_st = fall_stamp;
    if (rise_ev) begin
      if (!f.skip_rise) f.rise_flag = 1'b1;
      else              f.skip_rise = 1'b0;
      f.any_flag     = 1'b1;
      f.stable_level = 1'b1;
      rise_st        = now_t;
      f.rise_valid   = 1'b1;
      f.fall_valid   = 1'b0;
    end else if (fall_ev) begin
      if (!f.skip_fall) f.fall_flag = 1'b1;
      else              f.skip_fall = 1'b0;
      f.any_flag     = 1'b1;
      f.stable_level = 1'b0;
      fall_st        = now_t;
      f.fall_valid   = 1'b1;
      f.rise_valid   = 1'b0;
    end

    // Elapsed times with wrap
    el_hi = now_t - rise_st;
    el_lo = now_t - fall_st;

    // Long-state checks: high re-arms, low is one-shot
    hl = item.check_long && f.rise_valid &&
         (LONG_W'(el_hi) >= LONG_W'(cfg.high_long_limit_ms));
    ll = item.check_long && f.fall_valid &&
         (LONG_W'(el_lo) >= LONG_W'(cfg.low_long_limit_ms));

    res.debounced_level = f.stable_level;
    res.rise_pending    = f.rise_flag;
    res.fall_pending    = f.fall_flag;
    res.edge_pending    = f.any_flag;
    res.high_time_ms    = f.stable_level ? MS_W'(el_hi) : '0;
    res.low_time_ms     = f.stable_level ? '0 : MS_W'(el_lo);
    res.high_long       = hl;
    res.low_long        = ll;

    if (hl) rise_st = now_t;
    if (ll) f.fall_valid = 1'b0;

    // Drop pending flags after reporting them, when clear_events is set
    if (item.clear_events) begin
      f.rise_flag = 1'b0;
      f.fall_flag = 1'b0;
      f.any_flag  = 1'b0;
    end

    flags_nxt      = f;
    count_nxt      = cnt_new;
    rise_stamp_nxt = rise_st;
    fall_stamp_nxt = fall_st;
  end

endmodule
